@@ hdl/timed_id_block_cache_defines.svh @@
// Assertion macros shared by the blocking cache RTL.
`ifndef TIMED_ID_BLOCK_CACHE_DEFINES_SVH
`define TIMED_ID_BLOCK_CACHE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TIBC_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("timed_id_block_cache: assertion failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define TIBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("timed_id_block_cache: assertion failed");

// Checks a condition at every clock edge outside reset.
`define TIBC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("timed_id_block_cache: assertion failed");

`endif

@@ hdl/tibc_pkg.sv @@
`default_nettype none

package tibc_pkg;

  // Default number of cache entries.
  localparam int unsigned DefaultEntries = 16;

  // Blocking time after reset, in milliseconds.
  localparam logic [30:0] DurationReset = 31'd300000;

  // Register index, taken from address bit 2.
  localparam logic REG_DURATION = 1'b0;

  typedef enum logic {
    OP_LOOKUP = 1'b0,
    OP_STORE  = 1'b1
  } opcode_e;

  // Request token that walks the row of cells, one cell per cycle.
  typedef struct packed {
    logic        valid;
    opcode_e     op;
    logic [31:0] ident;
    logic [31:0] now_ms;
    logic        hit;
    logic        free_found;
    logic [31:0] sel_time;
  } token_t;

  // Write of one entry, broadcast to all cells.
  typedef struct packed {
    logic        en;
    logic [31:0] ident;
    logic [31:0] stamp;
  } entry_wr_t;

endpackage

`default_nettype wire

@@ hdl/tibc_cell.sv @@
`default_nettype none

module tibc_cell #(
  parameter int unsigned IdxW    = 4,
  parameter int unsigned CellIdx = 0
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [30:0]        dur_i,
  input  wire tibc_pkg::token_t   tok_i,
  input  wire logic [IdxW-1:0]    sel_i,
  output tibc_pkg::token_t        tok_o,
  output logic [IdxW-1:0]         sel_o,
  input  wire tibc_pkg::entry_wr_t wr_i,
  input  wire logic [IdxW-1:0]    wr_idx_i
);
  import tibc_pkg::*;

  localparam logic [IdxW-1:0] MyIdx = IdxW'(CellIdx);

  logic [31:0]     ident_q;
  logic [31:0]     time_q;
  token_t          tok_d, tok_q;
  logic [IdxW-1:0] sel_d, sel_q;
  logic [32:0]     age;
  logic            match;

  // Age is an exact signed difference, so both sides are sign-extended.
  always_comb begin
    tok_d = tok_i;
    sel_d = sel_i;
    age   = {tok_i.now_ms[31], tok_i.now_ms} - {time_q[31], time_q};
    match = (ident_q == tok_i.ident) && (tok_i.ident != '0);
    if (tok_i.op == OP_LOOKUP && match &&
        $signed(age) <= $signed({2'b00, dur_i})) begin
      tok_d.hit = 1'b1;
    end
    if (!tok_i.free_found) begin
      if (ident_q == '0) begin
        tok_d.free_found = 1'b1;
        sel_d            = MyIdx;
      end else if (CellIdx == 0 || $signed(time_q) < $signed(tok_i.sel_time)) begin
        tok_d.sel_time = time_q;
        sel_d          = MyIdx;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      sel_q <= '0;
    end else begin
      tok_q <= tok_d;
      sel_q <= sel_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ident_q <= '0;
      time_q  <= '0;
    end else if (wr_i.en && wr_idx_i == MyIdx) begin
      ident_q <= wr_i.ident;
      time_q  <= wr_i.stamp;
    end
  end

  assign tok_o = tok_q;
  assign sel_o = sel_q;

endmodule

`default_nettype wire

@@ hdl/timed_id_block_cache.sv @@
// Channel      | Direction | Handshake                        | Payload
// -------------+-----------+----------------------------------+-------------------------------
// Request      | in        | start, busy                      | opcode_i, ident_i, now_ms_i
// Result       | out       | done_o strobe, one cycle         | hit_o, slot_used_o
// Config (APB) | in/out    | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// A request is taken at an edge where start is high and busy is low. It then walks
// the row of CACHE_ENTRIES cells, one cell per cycle, and its result appears on the
// strobe as it leaves the last cell. Busy holds off new requests until then, and the
// next request can be taken in the cycle after the strobe.
// Reset clears the whole table at once; there is no clearing pass.
// The receiver cannot stall; the result is valid only in the cycle where done_o is high.
`default_nettype none

`include "timed_id_block_cache_defines.svh"

module timed_id_block_cache #(
  parameter int unsigned CACHE_ENTRIES = tibc_pkg::DefaultEntries
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Request channel.
  input  wire logic        start,
  output logic             busy,
  input  wire logic        opcode_i,
  input  wire logic [31:0] ident_i,
  input  wire logic [31:0] now_ms_i,
  // Result channel.
  output logic             done_o,
  output logic             hit_o,
  output logic [3:0]       slot_used_o,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import tibc_pkg::*;

  localparam int unsigned IdxW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  // The token chain: entry 0 is the request as it enters, entry c+1 is the
  // registered output of cell c. Each cell passes the token on every cycle.
  token_t                tok   [CACHE_ENTRIES+1];
  logic [IdxW-1:0]       sel   [CACHE_ENTRIES+1];
  logic [CACHE_ENTRIES-1:0] tok_vld;

  logic        busy_q, busy_d;
  logic        accept;
  logic [30:0] dur_q;
  entry_wr_t   wr;
  token_t      last;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  // The request token starts with no hit, no free entry found, and the
  // oldest-entry candidate cleared to zero; cell 0 seeds the candidate unless it is free.
  always_comb begin
    tok[0]            = '0;
    tok[0].valid      = accept;
    tok[0].op         = opcode_e'(opcode_i);
    tok[0].ident      = ident_i;
    tok[0].now_ms     = now_ms_i;
    sel[0]            = '0;
  end

  for (genvar c = 0; c < CACHE_ENTRIES; c++) begin : g_cell
    tibc_cell #(
      .IdxW    (IdxW),
      .CellIdx (c)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .dur_i    (dur_q),
      .tok_i    (tok[c]),
      .sel_i    (sel[c]),
      .tok_o    (tok[c+1]),
      .sel_o    (sel[c+1]),
      .wr_i     (wr),
      .wr_idx_i (sel[CACHE_ENTRIES])
    );
    assign tok_vld[c] = tok[c+1].valid;
  end

  assign last = tok[CACHE_ENTRIES];

  // When the token leaves the last cell, the chosen entry for a store is
  // known: the first free one, else the oldest. It is written in that cycle,
  // together with the result strobe, so the next request sees the new table.
  always_comb begin
    wr.en    = last.valid && last.op == OP_STORE;
    wr.ident = last.ident;
    wr.stamp = last.now_ms;
  end

  assign done_o      = last.valid;
  assign hit_o       = last.hit;
  assign slot_used_o = (last.op == OP_STORE) ? 4'(sel[CACHE_ENTRIES]) : 4'd0;

  // Busy is raised when a request is taken and dropped as its result leaves.
  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (last.valid) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  // Configuration register: the blocking duration, at address 0.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dur_q <= DurationReset;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DURATION) begin
      dur_q <= pwdata[30:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DURATION) ? {1'b0, dur_q} : 32'd0;

  // Only one request is ever in flight along the row of cells.
  `TIBC_ASSERT_ALWAYS(a_one_token, clk_i, rst_ni, $onehot0(tok_vld))
  // A result only leaves while the block is busy, and busy drops after it.
  `TIBC_ASSERT_SAME(a_done_busy, clk_i, rst_ni, done_o, busy_q)
  `TIBC_ASSERT_NEXT(a_done_free, clk_i, rst_ni, done_o, !busy_q)
  // A taken request keeps the block busy in the next cycle.
  `TIBC_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, accept, busy_q)

endmodule

`default_nettype wire

@@ test/timed_id_block_cache_test.sv @@
module timed_id_block_cache_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tibc_pkg::*;

  localparam int unsigned ENTRIES = DefaultEntries;

  // The duration register sits at byte address 0. Address 4 decodes to a register
  // index that does not exist, so a write there must leave the duration alone.
  localparam logic [2:0] DURATION_ADDR = {REG_DURATION, 2'b00};
  localparam logic [2:0] UNMAPPED_ADDR = {~REG_DURATION, 2'b00};

  // Cycles in which nothing moves on any port before the run is declared hung.
  // A request's walk along the row and the longest idle gap between requests are both
  // much shorter than this limit, so the correct block never comes near it.
  localparam int unsigned STALL_LIMIT = 2000;

  // One expected result of a request: lookups carry the hit flag, stores the slot.
  typedef struct packed {
    logic       hit;
    logic [3:0] slot;
  } verdict_t;

  // Keeps a shadow copy of the identifier table and of the blocking duration.
  // Every accepted request is resolved against the shadow right away, and the
  // verdict waits in order until the block strobes its result.
  class blocked_id_tracker;
    logic [31:0] held_ident[ENTRIES];
    logic [31:0] held_stamp[ENTRIES];
    logic [30:0] duration;
    verdict_t    pending_verdicts[$];
    int unsigned failures;
    int unsigned lookups;
    int unsigned hits;
    int unsigned stores;
    int unsigned evictions;

    function new();
      for (int k = 0; k < ENTRIES; k++) begin
        held_ident[k] = '0;
        held_stamp[k] = '0;
      end
      duration = DurationReset;
    endfunction

    function void note_request(opcode_e op, logic [31:0] ident, logic [31:0] now);
      verdict_t    v;
      longint      age;
      int unsigned slot;
      bit          found;
      v = '0;
      if (op == OP_LOOKUP) begin
        lookups++;
        // Identifier zero never hits. The age is an exact signed difference, so a
        // stamp in the future gives a negative age and counts as live.
        if (ident != '0) begin
          for (int k = 0; k < ENTRIES; k++) begin
            if (held_ident[k] == ident) begin
              age = longint'($signed(now)) - longint'($signed(held_stamp[k]));
              if (age <= longint'(duration)) v.hit = 1'b1;
            end
          end
        end
        if (v.hit) hits++;
      end else begin
        stores++;
        // First free entry wins; otherwise the smallest stamp, lowest index on a tie.
        slot  = 0;
        found = 1'b0;
        for (int k = 0; k < ENTRIES; k++) begin
          if (!found) begin
            if (held_ident[k] == '0) begin
              slot  = k;
              found = 1'b1;
            end else if ($signed(held_stamp[k]) < $signed(held_stamp[slot])) begin
              slot = k;
            end
          end
        end
        if (!found) evictions++;
        held_ident[slot] = ident;
        held_stamp[slot] = now;
        v.slot = slot[3:0];
      end
      pending_verdicts.push_back(v);
    endfunction

    function void check_result(logic hit, logic [3:0] slot);
      verdict_t want;
      if (pending_verdicts.size() == 0) begin
        $error("result with no request outstanding: hit=%0b slot_used=%0d", hit, slot);
        failures++;
        return;
      end
      want = pending_verdicts.pop_front();
      if (hit !== want.hit) begin
        $error("hit: expected %0b, actual %0b", want.hit, hit);
        failures++;
      end
      if (slot !== want.slot) begin
        $error("slot_used: expected %0d, actual %0d", want.slot, slot);
        failures++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        opcode_i = 1'b0;
  logic [31:0] ident_i = '0;
  logic [31:0] now_ms_i = '0;
  logic        done_o;
  logic        hit_o;
  logic [3:0]  slot_used_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  blocked_id_tracker sb = new();
  int unsigned       duration_settings;
  int unsigned       stall_cycles;

  timed_id_block_cache #(
    .CACHE_ENTRIES(ENTRIES)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .opcode_i   (opcode_i),
    .ident_i    (ident_i),
    .now_ms_i   (now_ms_i),
    .done_o     (done_o),
    .hit_o      (hit_o),
    .slot_used_o(slot_used_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // The receiver cannot push back, so every strobe is taken at the edge that ends
  // its cycle and checked against the oldest outstanding verdict.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(hit_o, slot_used_o);
  end

  // Any accepted request, any result and any register access count as progress.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || psel) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("Run hung: no request or result moved for %0d cycles.", STALL_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  // Writes a register over APB, then reads the duration back and compares it with
  // the shadow copy. Only bits 30:0 of the written word land in the register.
  task automatic program_duration(logic [2:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (addr[2] == REG_DURATION) begin
      sb.duration = value[30:0];
      duration_settings++;
    end
    // Go straight from the write's access phase into the setup phase of the read.
    pwrite  <= 1'b0;
    penable <= 1'b0;
    paddr   <= DURATION_ADDR;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== {1'b0, sb.duration}) begin
      $error("block_duration_ms: expected %0d, actual %0d", {1'b0, sb.duration}, prdata);
      sb.failures++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Presents one request and returns at the edge where it is taken. When idling is
  // allowed, start first drops about half the time, for a random gap that can outlast a
  // request's walk, so gaps land on every phase of the block's work. While start is
  // low the payload carries junk that the block must ignore.
  task automatic issue(opcode_e op, logic [31:0] id, logic [31:0] now, bit may_idle);
    if (may_idle && $urandom_range(0, 99) < 50) begin
      start    <= 1'b0;
      opcode_i <= 1'($urandom);
      ident_i  <= $urandom;
      now_ms_i <= $urandom;
      repeat ($urandom_range(1, 25)) @(posedge clk_i);
    end
    start    <= 1'b1;
    opcode_i <= op;
    ident_i  <= id;
    now_ms_i <= now;
    do @(posedge clk_i); while (busy);
    sb.note_request(op, id, now);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // One random phase at a given duration. Identifiers mostly come from a small pool
  // so that lookups find what earlier stores wrote, and times mostly drift around a
  // moving clock whose spread follows the duration, so ages fall on both sides of
  // it. Some lookups aim right at the expiry edge of a held entry, and the rest of
  // the traffic is full-range noise.
  task automatic run_phase(logic [31:0] setting, int unsigned count, bit steady);
    logic [31:0] pool[8];
    logic [31:0] base;
    logic [31:0] scale;
    logic [31:0] id;
    logic [31:0] now;
    opcode_e     op;
    int unsigned pick;
    int unsigned k;
    program_duration(DURATION_ADDR, setting);
    scale   = (sb.duration > 1000000) ? 32'd1000000 : {1'b0, sb.duration} + 32'd8;
    pool[0] = 32'h0000_0001;
    pool[1] = 32'hFFFF_FFFF;
    pool[2] = 32'h8000_0000;
    pool[3] = 32'h7FFF_FFFF;
    for (int i = 4; i < 8; i++) pool[i] = $urandom;
    base = $urandom;
    for (int n = 0; n < count; n++) begin
      op   = ($urandom_range(0, 99) < 40) ? OP_STORE : OP_LOOKUP;
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        id = pool[$urandom_range(0, 7)];
      end else if (pick < 70) begin
        id = '0;
      end else begin
        id = $urandom;
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        now  = base + $urandom_range(0, 2 * scale) - scale;
        base = base + $urandom_range(0, scale / 8);
      end else if (pick < 85 && op == OP_LOOKUP) begin
        // Age of duration - 1, duration or duration + 1 against a held entry.
        k   = $urandom_range(0, ENTRIES - 1);
        id  = sb.held_ident[k];
        now = sb.held_stamp[k] + sb.duration - 1 + $urandom_range(0, 2);
      end else begin
        now = $urandom;
      end
      issue(op, id, now, !steady);
    end
    drain();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A write to the unmapped address must leave the reset duration in place.
    program_duration(UNMAPPED_ADDR, 32'h0000_0001);

    // Directed part, at the reset duration. A zero lookup misses even though the
    // empty table is full of zero identifiers.
    issue(OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1'b1);
    // Extreme identifiers at extreme times.
    issue(OP_STORE,  32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    issue(OP_STORE,  32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    // An age of nearly 2^32 misses; a stamp far in the future hits.
    issue(OP_LOOKUP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    issue(OP_LOOKUP, 32'h8000_0000, 32'h8000_0000, 1'b1);
    // Storing identifier zero leaves the entry free, so the next store reuses it.
    issue(OP_STORE,  32'h0000_0000, 32'd5, 1'b1);
    issue(OP_STORE,  32'hFFFF_FFFF, 32'd5, 1'b1);
    // An age equal to the duration still hits; one more millisecond misses.
    issue(OP_LOOKUP, 32'hFFFF_FFFF, 32'd300005, 1'b1);
    issue(OP_LOOKUP, 32'hFFFF_FFFF, 32'd300006, 1'b1);
    issue(OP_LOOKUP, 32'h0000_0000, 32'd5, 1'b1);
    // Fill the rest of the table with equal stamps.
    for (int i = 0; i < ENTRIES - 3; i++) begin
      issue(OP_STORE, 32'h0000_0100 + i, 32'd100, 1'b1);
    end
    // A full table replaces the smallest stamp; among equal stamps the lowest index.
    issue(OP_STORE, 32'h5555_5555, 32'd100, 1'b1);
    issue(OP_STORE, 32'hAAAA_AAAA, 32'd100, 1'b1);
    issue(OP_STORE, 32'h0000_0001, 32'd100, 1'b1);
    drain();

    // Random phases over several durations, both extremes among them. The phase at
    // the largest duration runs back to back with no idle cycles at all.
    run_phase(32'h0000_0000, 60, 1'b0);
    run_phase(32'hFFFF_FFFF, 60, 1'b1);
    run_phase(32'd50, 80, 1'b0);
    run_phase($urandom, 80, 1'b0);
    run_phase({1'b0, DurationReset}, 60, 1'b0);
    run_phase($urandom_range(0, 5000), 60, 1'b0);

    // Give a stray late strobe time to show up.
    repeat (2 * ENTRIES + 4) @(posedge clk_i);

    $display("Covered %0d lookups (%0d hits) and %0d stores, %0d of them replacing an entry,",
             sb.lookups, sb.hits, sb.stores, sb.evictions);
    $display("over %0d duration settings from zero to the 31-bit maximum.", duration_settings);
    if (sb.failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
